FILE: src/rrtq_pkg.sv
// Shared types, constants and helpers for the round-robin task queue.
// No dependencies; every other file imports this package.
package rrtq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LINK_W    = $clog2(MAX_TASKS + 1);
  localparam int TASK_W    = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_TASKS);

  // command opcodes on the port
  localparam logic [2:0] OPC_ADD     = 3'd0;
  localparam logic [2:0] OPC_REMOVE  = 3'd1;
  localparam logic [2:0] OPC_BLOCK   = 3'd2;
  localparam logic [2:0] OPC_UNBLOCK = 3'd3;
  localparam logic [2:0] OPC_PICK    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PLACE   = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;

  typedef enum logic [1:0] {
    PL_ABSENT  = 2'd0,
    PL_READY   = 2'd1,
    PL_BLOCKED = 2'd2
  } place_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_BLOCK,
    OP_UNBLOCK,
    OP_PICK,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [TASK_W-1:0] task_id;
  } cmd_t;

  typedef struct packed {
    logic [TASK_W-1:0] picked_task;
    logic              idle_chosen;
    logic [1:0]        status;
  } rsp_t;

  // classified word passed from the front end to the back end
  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] task_id;
    logic              id_ok;
  } work_t;

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < NULL_LINK;
  endfunction

endpackage

FILE: src/rrtq_front.sv
// Front end of the task queue: takes command words and classifies them.
// Depends on rrtq_pkg; feeds rrtq_fifo.
module rrtq_front import rrtq_pkg::*; (
  input  logic  cmd_valid,
  input  cmd_t  cmd,
  output logic  cmd_stall,
  input  logic  q_full,
  output logic  q_push,
  output work_t q_word
);

  op_t op;

  always_comb begin
    case (cmd.opcode)
      OPC_ADD:     op = OP_ADD;
      OPC_REMOVE:  op = OP_REMOVE;
      OPC_BLOCK:   op = OP_BLOCK;
      OPC_UNBLOCK: op = OP_UNBLOCK;
      OPC_PICK:    op = OP_PICK;
      default:     op = OP_NONE;
    endcase
  end

  assign cmd_stall      = q_full;
  assign q_push         = cmd_valid && !q_full;
  assign q_word.op      = op;
  assign q_word.task_id = cmd.task_id;
  // ids beyond the task table count as absent
  assign q_word.id_ok   = 32'(cmd.task_id) < MAX_TASKS;

endmodule

FILE: src/rrtq_fifo.sv
// Short queue of classified words between front and back end.
// Depends on rrtq_pkg for the word type and depth.
module rrtq_fifo import rrtq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_word,
  output logic  full,
  input  logic  pop,
  output work_t pop_word,
  output logic  empty
);

  work_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QDEPTH);
  assign empty    = count == '0;
  assign pop_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

FILE: src/rrtq_back.sv
// Back end of the task queue: place marks, linked ready list and result register.
// Depends on rrtq_pkg; takes words from rrtq_fifo.
module rrtq_back import rrtq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_empty,
  input  work_t q_word,
  output logic  q_pop,
  output rsp_t  rsp,
  output logic  rsp_valid,
  input  logic  rsp_stall
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UNLINK = 4'b0010,
    S_APPEND = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [LINK_W-1:0] head, head_next;
  logic [LINK_W-1:0] tail, tail_next;
  logic [IDX_W-1:0]  tgt, tgt_next;
  logic              do_app, do_app_next;
  rsp_t              pend, pend_next;
  place_t            place [MAX_TASKS];

  logic              place_we;
  logic [IDX_W-1:0]  place_wa;
  place_t            place_wd;

  logic [LINK_W-1:0] next_mem [MAX_TASKS];
  logic [LINK_W-1:0] prev_mem [MAX_TASKS];
  logic              next_we, prev_we;
  logic [IDX_W-1:0]  next_wa, prev_wa, rd_addr;
  logic [LINK_W-1:0] next_wd, prev_wd;
  logic [LINK_W-1:0] next_rd, prev_rd;

  logic [IDX_W-1:0]  cur_idx;
  place_t            cur_place;
  logic [LINK_W-1:0] tgt_link, p_link, n_link;
  logic              head_ok, tail_ok, out_free;

  assign cur_idx   = IDX_W'(q_word.task_id);
  assign cur_place = q_word.id_ok ? place[cur_idx] : PL_ABSENT;
  assign tgt_link  = LINK_W'(tgt);
  assign head_ok   = link_ok(head);
  assign tail_ok   = link_ok(tail);
  assign out_free  = !rsp_valid || !rsp_stall;
  // head has no predecessor and tail no successor, whatever the stored links say
  assign p_link    = (tgt_link == head) ? NULL_LINK : prev_rd;
  assign n_link    = (tgt_link == tail) ? NULL_LINK : next_rd;

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    tgt_next    = tgt;
    do_app_next = do_app;
    pend_next   = pend;
    place_we    = 1'b0;
    place_wa    = cur_idx;
    place_wd    = PL_ABSENT;
    next_we     = 1'b0;
    next_wa     = '0;
    next_wd     = '0;
    prev_we     = 1'b0;
    prev_wa     = '0;
    prev_wd     = '0;
    rd_addr     = tgt;
    q_pop       = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          pend_next   = '0;
          tgt_next    = cur_idx;
          rd_addr     = cur_idx;
          do_app_next = 1'b0;
          state_next  = S_DONE;
          case (q_word.op)
            OP_ADD: begin
              if (!q_word.id_ok) begin
                pend_next.status = ST_PLACE;
              end else if (cur_place != PL_ABSENT) begin
                pend_next.status = ST_PRESENT;
              end else begin
                place_we   = 1'b1;
                place_wd   = PL_READY;
                state_next = S_APPEND;
              end
            end
            OP_REMOVE: begin
              if (cur_place == PL_ABSENT) begin
                pend_next.status = ST_PLACE;
              end else begin
                place_we = 1'b1;
                place_wd = PL_ABSENT;
                if (cur_place == PL_READY) begin
                  state_next = S_UNLINK;
                end
              end
            end
            OP_BLOCK: begin
              if (cur_place != PL_READY) begin
                pend_next.status = ST_PLACE;
              end else begin
                place_we   = 1'b1;
                place_wd   = PL_BLOCKED;
                state_next = S_UNLINK;
              end
            end
            OP_UNBLOCK: begin
              if (cur_place == PL_ABSENT) begin
                pend_next.status = ST_PLACE;
              end else begin
                place_we    = 1'b1;
                place_wd    = PL_READY;
                do_app_next = 1'b1;
                state_next  = (cur_place == PL_READY) ? S_UNLINK : S_APPEND;
              end
            end
            OP_PICK: begin
              if (!head_ok) begin
                pend_next.idle_chosen = 1'b1;
              end else begin
                // rotate the head to the tail
                pend_next.picked_task = TASK_W'(head);
                tgt_next              = IDX_W'(head);
                rd_addr               = IDX_W'(head);
                do_app_next           = 1'b1;
                state_next            = S_UNLINK;
              end
            end
            default: ;
          endcase
        end
      end
      S_UNLINK: begin
        if (link_ok(p_link)) begin
          next_we = 1'b1;
          next_wa = IDX_W'(p_link);
          next_wd = n_link;
        end else begin
          head_next = n_link;
        end
        if (link_ok(n_link)) begin
          prev_we = 1'b1;
          prev_wa = IDX_W'(n_link);
          prev_wd = p_link;
        end else begin
          tail_next = p_link;
        end
        state_next = do_app ? S_APPEND : S_DONE;
      end
      S_APPEND: begin
        prev_we = 1'b1;
        prev_wa = tgt;
        prev_wd = tail;
        if (tail_ok) begin
          next_we = 1'b1;
          next_wa = IDX_W'(tail);
          next_wd = tgt_link;
        end else begin
          head_next = tgt_link;
        end
        tail_next  = tgt_link;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NULL_LINK;
      tail      <= NULL_LINK;
      rsp_valid <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        place[i] <= PL_ABSENT;
      end
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      if (place_we) begin
        place[place_wa] <= place_wd;
      end
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt    <= tgt_next;
    do_app <= do_app_next;
    pend   <= pend_next;
    if (state == S_DONE && out_free) begin
      rsp <= pend;
    end
  end

  // link memories: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    next_rd <= next_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
  end

  a_head_tail_agree: assert property (@(posedge clk) disable iff (rst)
    head_ok == tail_ok)
    else $error("head and tail disagree on an empty list");

  a_append_ready: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND |-> place[tgt] == PL_READY)
    else $error("appending a task that is not marked ready");

  a_unlink_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_UNLINK |-> head_ok)
    else $error("unlinking from an empty ready list");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !rsp_valid) |=> rsp_valid)
    else $error("finished word not placed in the result register");

endmodule

FILE: src/round_robin_task_queue.sv
// Round-robin task queue: front end, word queue and back end.
// A command with no list change goes from idle straight to done; an append or a single
// unlink takes one list step, and pick and unblock of a ready task unlink then append.
// The back end's sequencer takes one command at a time and writes each link memory at
// most once per step; later commands wait in the word queue. Synchronous reset clears
// place marks, head, tail, queue and rsp_valid; rsp and link memories are not cleared.
module round_robin_task_queue import rrtq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_stall,
  output logic rsp_valid,
  output rsp_t rsp,
  input  logic rsp_stall
);

  logic  q_full, q_empty, q_push, q_pop;
  work_t push_word, pop_word;

  rrtq_front u_front (
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (push_word)
  );

  rrtq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .empty     (q_empty)
  );

  rrtq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_word    (pop_word),
    .q_pop     (q_pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule
